// File: src/nps_pkg.sv
// nps_pkg: shared constants, command codes and control types for the
// nearest point search block. No dependencies.
package nps_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned CmdBits      = 2;
  localparam int unsigned IndexOutBits = 8;

  typedef enum logic [CmdBits-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // controls for one ring cell
  typedef struct packed {
    logic shift;
    logic load;
  } ring_ctrl_t;

  // tag riding with a point through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } beat_tag_t;

endpackage

// File: src/nps_if.sv
// nps_if: valid/ready channel interfaces for the nearest point search block.
// Depends on nps_pkg for widths and defaults.
interface nps_in_if #(
  parameter int unsigned COORD_BITS = nps_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic [nps_pkg::CmdBits-1:0]  cmd;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, output ready);
endinterface

interface nps_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [nps_pkg::IndexOutBits-1:0] point_index;

  modport source (output valid, ok, point_index, input ready);
  modport sink   (input valid, ok, point_index, output ready);
endinterface

// File: src/nps_cell.sv
// nps_cell: one slot of the point ring; holds a point, takes a load or
// its neighbor's point. Depends on nps_pkg.
module nps_cell #(
  parameter int unsigned COORD_BITS = nps_pkg::CoordBitsDef
) (
  input  logic                      clk_i,
  input  nps_pkg::ring_ctrl_t       ctrl_i,
  input  logic [3*COORD_BITS-1:0]   load_pt_i,
  input  logic [3*COORD_BITS-1:0]   next_pt_i,
  output logic [3*COORD_BITS-1:0]   pt_o
);

  logic [3*COORD_BITS-1:0] pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    if (ctrl_i.shift) begin
      pt_d = next_pt_i;
    end else if (ctrl_i.load) begin
      pt_d = load_pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;

endmodule

// File: src/nps_dist.sv
// nps_dist: three-stage pipeline giving the exact squared distance between
// a ring point and the query. Depends on nps_pkg.
module nps_dist #(
  parameter int unsigned COORD_BITS = nps_pkg::CoordBitsDef,
  parameter int unsigned IDX_BITS   = 8,
  localparam int unsigned DistBits  = 2 * COORD_BITS + 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nps_pkg::beat_tag_t      tag_i,
  input  logic [IDX_BITS-1:0]     idx_i,
  input  logic [3*COORD_BITS-1:0] pt_i,
  input  logic [3*COORD_BITS-1:0] qry_i,
  output nps_pkg::beat_tag_t      tag_o,
  output logic [IDX_BITS-1:0]     idx_o,
  output logic [DistBits-1:0]     dist_o
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned SqBits   = 2 * COORD_BITS + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  nps_pkg::beat_tag_t tag1_q, tag2_q, tag3_q;
  logic [IDX_BITS-1:0] idx1_q, idx2_q, idx3_q;
  logic signed [DiffBits-1:0] diff_d [3];
  logic signed [DiffBits-1:0] diff_q [3];
  logic signed [ProdBits-1:0] prod   [3];
  logic [SqBits-1:0]          sq_q   [3];
  logic [DistBits-1:0]        dist_q, dist_d;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [COORD_BITS-1:0] a, b;
    assign a = pt_i[k*COORD_BITS +: COORD_BITS];
    assign b = qry_i[k*COORD_BITS +: COORD_BITS];
    assign diff_d[k] = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    // square of a signed value is never negative and fits SqBits
    assign prod[k] = diff_q[k] * diff_q[k];
  end

  assign dist_d = DistBits'(sq_q[0]) + DistBits'(sq_q[1]) + DistBits'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    for (int k = 0; k < 3; k++) begin
      diff_q[k] <= diff_d[k];
      sq_q[k]   <= prod[k][SqBits-1:0];
    end
    dist_q <= dist_d;
  end

  assign tag_o  = tag3_q;
  assign idx_o  = idx3_q;
  assign dist_o = dist_q;

endmodule

// File: src/nearest_point_search.sv
// nearest_point_search: top level; ring of point cells, distance pipeline
// and command sequencer. Depends on nps_pkg, nps_if, nps_cell, nps_dist.
//
// Keeps up to MAX_POINTS 3-D points (signed fixed point, COORD_BITS per axis)
// in a ring of cells. A load beat stores its point at the next free slot and
// returns that slot's index (low 8 bits), or ok=0 when the table is full.
// A clear beat empties the table and returns ok=1. A query beat returns the
// index of the stored point with the smallest exact squared distance to the
// query point, the lowest index on a tie, or ok=0 on an empty table; an
// unknown command changes nothing and returns ok=0. Index is 0 whenever ok
// is 0. Load, clear, unknown commands and queries on an empty table answer
// in the cycle after they are taken. A query on a non-empty table scans:
// the ring rotates one full turn, feeding one point per cycle into
// a three-stage distance pipeline, followed by one compare stage and the
// result register. One beat is worked on at a time; the result sits in an
// output register, and a new beat is taken as soon as that register is
// free or being read. No clearing pass after reset.
module nearest_point_search #(
  parameter int unsigned MAX_POINTS = nps_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = nps_pkg::CoordBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  nps_in_if.sink          in_i,
  nps_out_if.source       out_o
);

  localparam int unsigned IdxBits  = $clog2(MAX_POINTS);
  localparam int unsigned CntBits  = IdxBits + 1;
  localparam int unsigned PtBits   = 3 * COORD_BITS;
  localparam int unsigned DistBits = 2 * COORD_BITS + 3;
  localparam int unsigned OutBits  = nps_pkg::IndexOutBits;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e               state_q;
  logic [CntBits-1:0]   count_q;
  logic [IdxBits-1:0]   feed_idx_q;
  logic                 feed_on_q;
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [OutBits-1:0]   out_idx_q;

  // payload registers
  logic [PtBits-1:0]    qry_q;
  logic [DistBits-1:0]  best_q;
  logic [IdxBits-1:0]   best_idx_q;

  logic                 out_free;
  logic                 out_load;
  logic                 in_fire;
  logic                 table_full;
  logic [PtBits-1:0]    in_pt;
  nps_pkg::cmd_e        cmd;

  // ring of point cells, head is cell 0
  logic [PtBits-1:0]    cell_pt [MAX_POINTS];
  logic                 ring_shift;
  logic                 do_load;

  // distance pipeline
  nps_pkg::beat_tag_t   feed_tag, res_tag;
  logic [IdxBits-1:0]   res_idx;
  logic [DistBits-1:0]  res_dist;
  logic                 res_in_table;
  logic                 take_best;

  // index widening before cutting to the 8-bit result field
  logic [IdxBits+OutBits-1:0] count_wide, best_wide;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cmd        = nps_pkg::cmd_e'(in_i.cmd);
  assign table_full = (count_q == CntBits'(MAX_POINTS));
  assign in_pt      = {in_i.coord_z, in_i.coord_y, in_i.coord_x};
  assign do_load    = in_fire && (cmd == nps_pkg::CMD_LOAD) && !table_full;
  assign ring_shift = (state_q == ST_SCAN) && feed_on_q;

  // a new answer enters the output register: every beat but a scanning query,
  // or the end of a scan
  assign out_load = (in_fire && !((cmd == nps_pkg::CMD_QUERY) && (count_q != '0))) ||
                    ((state_q == ST_RESULT) && out_free);

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    nps_pkg::ring_ctrl_t ctrl;
    assign ctrl.shift = ring_shift;
    assign ctrl.load  = do_load && (count_q[IdxBits-1:0] == IdxBits'(i));

    nps_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .load_pt_i (in_pt),
      .next_pt_i (cell_pt[(i + 1) % MAX_POINTS]),
      .pt_o      (cell_pt[i])
    );
  end

  // one point per cycle leaves the ring head; a full turn restores order
  assign feed_tag.valid = ring_shift;
  assign feed_tag.last  = (feed_idx_q == IdxBits'(MAX_POINTS - 1));

  nps_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (IdxBits)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (feed_tag),
    .idx_i  (feed_idx_q),
    .pt_i   (cell_pt[0]),
    .qry_i  (qry_q),
    .tag_o  (res_tag),
    .idx_o  (res_idx),
    .dist_o (res_dist)
  );

  // only slots below the fill count take part; slot 0 seeds the minimum
  assign res_in_table = ({1'b0, res_idx} < count_q);
  assign take_best    = res_tag.valid &&
                        ((res_idx == '0) || (res_in_table && (res_dist < best_q)));

  assign count_wide = {{OutBits{1'b0}}, count_q[IdxBits-1:0]};
  assign best_wide  = {{OutBits{1'b0}}, best_idx_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      qry_q <= in_pt;
    end
    if (take_best) begin
      best_q     <= res_dist;
      best_idx_q <= res_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      feed_idx_q  <= '0;
      feed_on_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (cmd)
              nps_pkg::CMD_LOAD: begin
                out_ok_q    <= !table_full;
                out_idx_q   <= table_full ? '0 : count_wide[OutBits-1:0];
                if (!table_full) begin
                  count_q <= count_q + 1'b1;
                end
              end
              nps_pkg::CMD_QUERY: begin
                if (count_q == '0) begin
                  out_ok_q    <= 1'b0;
                  out_idx_q   <= '0;
                end else begin
                  state_q    <= ST_SCAN;
                  feed_idx_q <= '0;
                  feed_on_q  <= 1'b1;
                end
              end
              nps_pkg::CMD_CLEAR: begin
                count_q     <= '0;
                out_ok_q    <= 1'b1;
                out_idx_q   <= '0;
              end
              default: begin
                out_ok_q    <= 1'b0;
                out_idx_q   <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (feed_on_q) begin
            if (feed_tag.last) begin
              feed_on_q <= 1'b0;
            end else begin
              feed_idx_q <= feed_idx_q + 1'b1;
            end
          end
          // last point has left the compare stage
          if (res_tag.valid && res_tag.last) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_ok_q    <= 1'b1;
            out_idx_q   <= best_wide[OutBits-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.point_index = out_idx_q;

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for nearest_point_search, with a scoreboard
// class holding its own point table and plain tasks that drive the command channel.
// Depends on nps_pkg, nps_if and the nearest_point_search rtl.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TablePoints = nps_pkg::MaxPointsDef;
  localparam int unsigned CoordW      = nps_pkg::CoordBitsDef;
  localparam int unsigned IdxOutW     = nps_pkg::IndexOutBits;
  localparam int unsigned RandomItems = 1050;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned TailCycles  = TablePoints + 4 + 50;
  localparam int unsigned HoldAtBeat  = 200;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CalmFirst   = 400;
  localparam int unsigned CalmLast    = 650;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic               ok;
    logic [IdxOutW-1:0] point_index;
  } answer_t;

  // scoreboard: mirrors the point table and queues the answers it predicts
  class nearest_point_scoreboard;
    coord_t      px [TablePoints];
    coord_t      py [TablePoints];
    coord_t      pz [TablePoints];
    int unsigned n_points;
    int unsigned n_errors;
    answer_t     pending [$];

    function new();
      n_points = 0;
      n_errors = 0;
    endfunction

    // exact squared distance, widened so nothing wraps
    function longint dist_sq(int unsigned i, coord_t x, coord_t y, coord_t z);
      longint dx;
      longint dy;
      longint dz;
      dx = longint'(px[i]) - longint'(x);
      dy = longint'(py[i]) - longint'(y);
      dz = longint'(pz[i]) - longint'(z);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void note_command(nps_pkg::cmd_e cmd, coord_t x, coord_t y, coord_t z);
      answer_t     ans;
      longint      best;
      longint      d;
      int unsigned best_i;
      ans = '0;
      case (cmd)
        nps_pkg::CMD_LOAD: begin
          if (n_points < TablePoints) begin
            px[n_points] = x;
            py[n_points] = y;
            pz[n_points] = z;
            ans.ok = 1'b1;
            ans.point_index = IdxOutW'(n_points);
            n_points++;
          end
        end
        nps_pkg::CMD_QUERY: begin
          if (n_points > 0) begin
            best = dist_sq(0, x, y, z);
            best_i = 0;
            for (int unsigned i = 1; i < n_points; i++) begin
              d = dist_sq(i, x, y, z);
              // strict compare keeps the lowest index on a tie
              if (d < best) begin
                best = d;
                best_i = i;
              end
            end
            ans.ok = 1'b1;
            ans.point_index = IdxOutW'(best_i);
          end
        end
        nps_pkg::CMD_CLEAR: begin
          n_points = 0;
          ans.ok = 1'b1;
        end
        default: ;
      endcase
      pending = {pending, ans};
    endfunction

    function void check_answer(logic ok, logic [IdxOutW-1:0] point_index);
      answer_t want;
      if (pending.size() == 0) begin
        $error("answer beat with nothing pending: ok=%0d point_index=%0d",
               ok, point_index);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      if (ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, ok);
        n_errors++;
      end
      if (point_index !== want.point_index) begin
        $error("point_index: expected %0d, actual %0d", want.point_index, point_index);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nps_in_if #(.COORD_BITS(CoordW)) in_bus ();
  nps_out_if                       out_bus ();

  nearest_point_search #(
    .MAX_POINTS(TablePoints),
    .COORD_BITS(CoordW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  nearest_point_scoreboard sb;

  int unsigned beats_sent;
  int unsigned answers_seen;
  int unsigned hold_left;
  bit          calm;

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // both sides drop idling for a stretch in the middle of the run
  assign calm = (beats_sent >= CalmFirst) && (beats_sent < CalmLast);

  // ---------------------------------------------------------------------
  // command side: one beat per call, payload changes at the falling edge
  // ---------------------------------------------------------------------
  task automatic send_command(nps_pkg::cmd_e cmd, coord_t x, coord_t y, coord_t z);
    @(negedge clk_i);
    // random gaps, about a third of the cycles
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_bus.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_bus.valid   = 1'b1;
    in_bus.cmd     = cmd;
    in_bus.coord_x = x;
    in_bus.coord_y = y;
    in_bus.coord_z = z;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_command(cmd, x, y, z);
    beats_sent++;
  endtask

  // coordinate mix: extremes, a tight cluster near zero for ties, full range
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: return coord_t'(16'sh7FFF);
        1: return coord_t'(16'sh8000);
        2: return '0;
        default: return '1;
      endcase
    end else if (pick < 40) begin
      return coord_t'($signed($urandom_range(0, 16)) - 8);
    end
    return coord_t'($urandom);
  endfunction

  function automatic int unsigned stored_slot();
    int unsigned n;
    n = (sb.n_points < TablePoints) ? sb.n_points : TablePoints;
    return $urandom_range(0, n - 1);
  endfunction

  task automatic load_random();
    int unsigned s;
    // some loads copy a stored point so that queries see exact ties
    if (sb.n_points > 0 && $urandom_range(0, 4) == 0) begin
      s = stored_slot();
      send_command(nps_pkg::CMD_LOAD, sb.px[s], sb.py[s], sb.pz[s]);
    end else begin
      send_command(nps_pkg::CMD_LOAD, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic query_random();
    int unsigned s;
    int unsigned mode;
    mode = $urandom_range(0, 2);
    if (sb.n_points == 0 || mode == 2) begin
      send_command(nps_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
    end else begin
      s = stored_slot();
      if (mode == 0) begin
        send_command(nps_pkg::CMD_QUERY, sb.px[s], sb.py[s], sb.pz[s]);
      end else begin
        // small nudge off a stored point, close races between neighbors
        send_command(nps_pkg::CMD_QUERY,
                     sb.px[s] + coord_t'($signed($urandom_range(0, 6)) - 3),
                     sb.py[s] + coord_t'($signed($urandom_range(0, 6)) - 3),
                     sb.pz[s] + coord_t'($signed($urandom_range(0, 6)) - 3));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // directed part: extremes, ties, empty and full-range cases
  // ---------------------------------------------------------------------
  task automatic run_directed();
    send_command(nps_pkg::CMD_QUERY, '0, '0, '0);                      // empty table
    send_command(nps_pkg::CMD_CLEAR, '0, '0, '0);                      // clear when empty
    send_command(nps_pkg::CMD_RSVD, 16'sh7FFF, 16'sh8000, '1);         // unknown command
    send_command(nps_pkg::CMD_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);  // index 0
    send_command(nps_pkg::CMD_LOAD, 16'sh8000, 16'sh8000, 16'sh8000);  // index 1
    send_command(nps_pkg::CMD_LOAD, '0, '0, '0);                       // index 2
    send_command(nps_pkg::CMD_LOAD, '0, '0, '0);                       // duplicate, index 3
    send_command(nps_pkg::CMD_QUERY, '0, '0, '0);                      // tie, lowest wins
    send_command(nps_pkg::CMD_QUERY, 16'sh8000, 16'sh8000, 16'sh8000);
    send_command(nps_pkg::CMD_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_command(nps_pkg::CMD_QUERY, '1, '1, '1);                      // just off origin
    send_command(nps_pkg::CMD_QUERY, 16'sh7FFF, 16'sh8000, '0);        // largest spread
    send_command(nps_pkg::CMD_LOAD, 16'sh5555, 16'shAAAA, 16'sh00FF);
    send_command(nps_pkg::CMD_LOAD, 16'shAAAA, 16'sh5555, 16'shFF00);
    send_command(nps_pkg::CMD_QUERY, 16'sh5555, 16'shAAAA, 16'sh00FF);
    send_command(nps_pkg::CMD_LOAD, 16'sh0002, '0, '0);
    send_command(nps_pkg::CMD_LOAD, 16'shFFFE, '0, '0);
    send_command(nps_pkg::CMD_QUERY, 16'sh0001, '0, '0);
    send_command(nps_pkg::CMD_RSVD, '0, '0, '0);                       // state untouched
    send_command(nps_pkg::CMD_QUERY, 16'shAAAA, 16'sh5555, 16'shFF00);
    send_command(nps_pkg::CMD_CLEAR, 16'sh1234, 16'sh5678, 16'sh9ABC);
    send_command(nps_pkg::CMD_QUERY, '0, '0, '0);                      // empty again
    send_command(nps_pkg::CMD_LOAD, 16'sh0100, 16'sh0100, 16'sh0100);  // back to index 0
    send_command(nps_pkg::CMD_QUERY, 16'sh8000, 16'sh7FFF, 16'sh8000);
  endtask

  // ---------------------------------------------------------------------
  // random part: clear, a run of loads, then mostly queries
  // ---------------------------------------------------------------------
  task automatic run_random();
    int unsigned target;
    int unsigned phase;
    int unsigned full_fills;
    int unsigned n_load;
    int unsigned n_query;
    int unsigned r;
    bit          fill;
    target = beats_sent + RandomItems;
    phase = 0;
    full_fills = 0;
    while (beats_sent < target) begin
      fill = (phase == 1) || (full_fills < 2 && $urandom_range(0, 19) == 0);
      if (phase == 0 || fill || $urandom_range(0, 4) != 0) begin
        send_command(nps_pkg::CMD_CLEAR, rand_coord(), rand_coord(), rand_coord());
      end
      if (fill) begin
        // fill the table, then push past it
        full_fills++;
        while (sb.n_points < TablePoints) load_random();
        n_load = $urandom_range(1, 4);
        n_query = 6;
      end else begin
        n_load = $urandom_range(0, 12);
        n_query = $urandom_range(1, 8);
      end
      repeat (n_load) load_random();
      repeat (n_query) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          load_random();
        end else if (r < 20) begin
          send_command(nps_pkg::CMD_RSVD, rand_coord(), rand_coord(), rand_coord());
        end else begin
          query_random();
        end
      end
      phase++;
    end
    @(negedge clk_i);
    in_bus.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // answer side: ready at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        // long hold-off so the block backs up into the command channel
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        out_bus.ready = calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) begin
      sb.check_answer(out_bus.ok, out_bus.point_index);
      answers_seen++;
      if (answers_seen == HoldAtBeat) hold_left = HoldCycles;
    end
  end

  // watchdog: too long without any beat on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    sb = new();
    beats_sent     = 0;
    answers_seen   = 0;
    hold_left      = 0;
    in_bus.valid   = 1'b0;
    in_bus.cmd     = nps_pkg::CMD_LOAD;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.coord_z = '0;
    out_bus.ready  = 1'b0;
    rst_ni         = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random();

    // drain, then watch a while for stray answers
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
